// ----- design/orfs_pkg.sv -----
// Package for the obstacle repulsive force summer: widths, constants, shared types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package orfs_pkg;
    localparam int FRACTION_BITS = 16;
    localparam int DIR_BITS = 30;
    localparam logic [31:0] GAIN_RESET = 32'(10 << FRACTION_BITS);
    localparam logic [31:0] RANGE_RESET = 32'(30 << FRACTION_BITS);
    localparam logic CFG_GAIN = 1'b0;
    localparam logic CFG_RANGE = 1'b1;
    localparam logic [46:0] MAX47 = {47{1'b1}};

    typedef struct packed {
        logic        use_obs;
        logic        zero_dist;
        logic        last;
        logic [31:0] qx;
        logic [31:0] qy;
        logic        sx;
        logic        sy;
        logic [32:0] adx;
        logic [32:0] ady;
    } orfs_job_t;
endpackage
`default_nettype wire

// ----- design/orfs_front.sv -----
// Front end: accepts items, forms deltas, classifies and queues jobs.
// Depends on orfs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module orfs_front import orfs_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [31:0] s_query_x,
    input  wire logic [31:0] s_query_y,
    input  wire logic [31:0] s_obstacle_x,
    input  wire logic [31:0] s_obstacle_y,
    input  wire logic        s_has_obstacle,
    input  wire logic        s_last_in_batch,
    output orfs_job_t        job,
    output logic             job_valid,
    input  wire logic        job_take
);
    orfs_job_t q_reg [2];
    logic [1:0] cnt_reg;
    logic rd_reg, wr_reg;
    orfs_job_t nj;
    logic signed [32:0] dx, dy;
    logic acc;

    always_comb begin
        dx = 33'(signed'(s_query_x)) - 33'(signed'(s_obstacle_x));
        dy = 33'(signed'(s_query_y)) - 33'(signed'(s_obstacle_y));
        nj.qx = s_query_x;
        nj.qy = s_query_y;
        nj.last = s_last_in_batch;
        nj.sx = dx[32];
        nj.sy = dy[32];
        nj.adx = dx[32] ? 33'(-dx) : dx;
        nj.ady = dy[32] ? 33'(-dy) : dy;
        nj.use_obs = s_has_obstacle && !(s_obstacle_x == '0 && s_obstacle_y == '0)
                     && !(dx == '0 && dy == '0);
        nj.zero_dist = s_has_obstacle && !(s_obstacle_x == '0 && s_obstacle_y == '0)
                       && dx == '0 && dy == '0;
    end

    assign s_ready = cnt_reg != 2'd2;
    assign acc = s_valid && s_ready && (s_has_obstacle || s_last_in_batch);
    assign job_valid = cnt_reg != 2'd0;
    assign job = q_reg[rd_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            rd_reg <= 1'b0;
            wr_reg <= 1'b0;
        end else begin
            if (acc) begin
                q_reg[wr_reg] <= nj;
                wr_reg <= !wr_reg;
            end
            if (job_take && job_valid) rd_reg <= !rd_reg;
            cnt_reg <= cnt_reg + 2'(acc) - 2'(job_take && job_valid);
        end
    end
endmodule
`default_nettype wire

// ----- design/orfs_seq.sv -----
// Shared iterative arithmetic: restoring divider and bitwise square root.
// Depends on orfs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module orfs_seq import orfs_pkg::*; (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         start,
    input  wire logic         is_sqrt,
    input  wire logic [127:0] num,
    input  wire logic [63:0]  den,
    output logic              busy,
    output logic [127:0]      quo
);
    logic [127:0] n_reg, q_reg;
    logic [64:0] r_reg;
    logic [63:0] d_reg;
    logic [7:0] cnt_reg;
    logic sq_reg;
    logic [64:0] rs;
    logic [66:0] rt, tr;
    assign busy = cnt_reg != '0;
    assign quo = q_reg;
    assign rs = {r_reg[63:0], n_reg[127]};
    assign rt = {r_reg[64:0], n_reg[127:126]};
    assign tr = {1'b0, q_reg[63:0], 2'b01};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (start) begin
            n_reg <= num;
            d_reg <= den;
            q_reg <= '0;
            r_reg <= '0;
            sq_reg <= is_sqrt;
            cnt_reg <= is_sqrt ? 8'd64 : 8'd128;
        end else if (busy) begin
            cnt_reg <= cnt_reg - 8'd1;
            if (sq_reg) begin
                n_reg <= {n_reg[125:0], 2'b00};
                if (rt >= tr) begin
                    r_reg <= 65'(rt - tr);
                    q_reg <= {q_reg[126:0], 1'b1};
                end else begin
                    r_reg <= rt[64:0];
                    q_reg <= {q_reg[126:0], 1'b0};
                end
            end else begin
                n_reg <= {n_reg[126:0], 1'b0};
                if (r_reg[63] || rs >= {1'b0, d_reg}) begin
                    r_reg <= 65'(rs - {1'b0, d_reg});
                    q_reg <= {q_reg[126:0], 1'b1};
                end else begin
                    r_reg <= rs;
                    q_reg <= {q_reg[126:0], 1'b0};
                end
            end
        end
    end
endmodule
`default_nettype wire

// ----- design/orfs_back.sv -----
// Back end: per-obstacle term sequencer, saturating sums, batch close.
// Depends on orfs_pkg and orfs_seq.
`timescale 1ns / 1ps
`default_nettype none
module orfs_back import orfs_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic [31:0] gain,
    input  wire logic [31:0] range_r,
    input  orfs_job_t        job,
    input  wire logic        job_valid,
    output logic             job_take,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_out_query_x,
    output logic [31:0]      m_out_query_y,
    output logic [47:0]      m_force_x,
    output logic [47:0]      m_force_y,
    output logic [46:0]      m_force_magnitude,
    output logic             m_saturated
);
    localparam logic [4:0] S_IDLE = 5'd0, S_SQ = 5'd1, S_D2 = 5'd2, S_DW = 5'd3,
        S_GM = 5'd4, S_GD = 5'd5, S_GW = 5'd6, S_SD = 5'd7, S_SW = 5'd8,
        S_PM = 5'd9, S_PD = 5'd10, S_PW = 5'd11, S_ACC = 5'd12, S_MA = 5'd13,
        S_MB = 5'd14, S_MS = 5'd15, S_MW = 5'd16, S_OUT = 5'd17, S_M0 = 5'd18;

    logic [4:0] st_reg;
    logic ax_reg;
    orfs_job_t j_reg;
    logic [65:0] sqx_reg, sqy_reg, d2_reg, r2_reg;
    logic [63:0] d_reg, g_reg, p_reg;
    logic signed [47:0] sx_reg, sy_reg;
    logic clip_reg;
    logic [47:0] mx_reg, my_reg;
    logic [95:0] sq_reg;
    logic [2:0] pp_reg;
    logic [46:0] mag_reg;
    logic start, is_sqrt, busy;
    logic [127:0] num, quo;
    logic [63:0] den;
    logic [32:0] adel;
    logic [46:0] term;
    logic tclip;
    logic signed [48:0] tsum;
    logic signed [47:0] cur;
    logic sum_hi, sum_lo;
    logic [63:0] rsq, gain_prod, dir_prod;
    logic [47:0] mop;
    logic [23:0] pa, pb;
    logic [6:0] psh;
    logic [47:0] pprod;
    logic [95:0] pterm;

    orfs_seq u_seq (.aclk(aclk), .aresetn(aresetn), .start(start), .is_sqrt(is_sqrt),
        .num(num), .den(den), .busy(busy), .quo(quo));

    assign job_take = st_reg == S_IDLE && job_valid;
    assign adel = ax_reg ? j_reg.ady : j_reg.adx;
    assign tclip = (quo[127:DIR_BITS] >> 47) != '0;
    assign term = tclip ? MAX47 : quo[DIR_BITS +: 47];
    assign cur = ax_reg ? sy_reg : sx_reg;
    assign tsum = 49'(cur) + ((ax_reg ? j_reg.sy : j_reg.sx)
                  ? -49'(signed'({2'b0, term})) : 49'(signed'({2'b0, term})));
    assign sum_hi = tsum > 49'sh7FFFFFFFFFFF;
    assign sum_lo = tsum < -49'sh800000000000;
    assign rsq = range_r * range_r;
    assign gain_prod = gain * (range_r - quo[31:0]);
    assign dir_prod = g_reg[31:0] * quo[31:0];

    always_comb begin
        mop = (pp_reg >= 3'd3) ? my_reg : mx_reg;
        pa = mop[23:0];
        pb = mop[23:0];
        psh = 7'd0;
        unique case (pp_reg) inside
            3'd1, 3'd4: begin
                pb = mop[47:24];
                psh = 7'd25;
            end
            3'd2, 3'd5: begin
                pa = mop[47:24];
                pb = mop[47:24];
                psh = 7'd48;
            end
            default: ;
        endcase
    end

    assign pprod = pa * pb;
    assign pterm = 96'(pprod) << psh;

    always_comb begin
        start = 1'b0;
        is_sqrt = 1'b0;
        num = '0;
        den = 64'd1;
        unique case (st_reg)
            S_D2: begin
                start = 1'b1;
                is_sqrt = 1'b1;
                num = 128'(d2_reg);
            end
            S_GD: begin
                start = 1'b1;
                num = 128'(g_reg);
                den = 64'(range_r);
            end
            S_SD: begin
                start = 1'b1;
                num = 128'(adel) << DIR_BITS;
                den = d_reg;
            end
            S_PD: begin
                start = 1'b1;
                num = 128'(p_reg) << (2 * FRACTION_BITS);
                den = d2_reg[63:0];
            end
            S_MS: begin
                start = 1'b1;
                is_sqrt = 1'b1;
                num = 128'(sq_reg);
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= S_IDLE;
            m_valid <= 1'b0;
            sx_reg <= '0;
            sy_reg <= '0;
            clip_reg <= 1'b0;
        end else begin
            unique case (st_reg)
                S_IDLE: if (job_valid) begin
                    j_reg <= job;
                    ax_reg <= 1'b0;
                    if (job.zero_dist) clip_reg <= 1'b1;
                    if (job.use_obs && job.adx <= 33'(range_r) && job.ady <= 33'(range_r))
                        st_reg <= S_SQ;
                    else if (job.last) st_reg <= S_M0;
                end
                S_SQ: begin
                    sqx_reg <= j_reg.adx * j_reg.adx;
                    sqy_reg <= j_reg.ady * j_reg.ady;
                    r2_reg <= {2'b0, rsq};
                    d2_reg <= '0;
                    st_reg <= S_DW;
                end
                S_DW: begin
                    d2_reg <= sqx_reg + sqy_reg;
                    st_reg <= S_GM;
                end
                S_GM: begin
                    if (d2_reg[65:64] != '0 || d2_reg > r2_reg)
                        st_reg <= j_reg.last ? S_M0 : S_IDLE;
                    else st_reg <= S_D2;
                end
                S_D2: st_reg <= S_GW;
                S_GW: if (!busy) begin
                    d_reg <= quo[63:0];
                    g_reg <= gain_prod;
                    st_reg <= S_GD;
                end
                S_GD: st_reg <= S_SW;
                S_SW: if (!busy) begin
                    g_reg <= quo[63:0];
                    st_reg <= S_SD;
                end
                S_SD: st_reg <= S_PM;
                S_PM: if (!busy) begin
                    p_reg <= dir_prod;
                    st_reg <= S_PD;
                end
                S_PD: st_reg <= S_PW;
                S_PW: if (!busy) st_reg <= S_ACC;
                S_ACC: begin
                    clip_reg <= clip_reg || tclip || sum_hi || sum_lo;
                    if (sum_hi) begin
                        if (ax_reg) sy_reg <= 48'h7FFFFFFFFFFF;
                        else sx_reg <= 48'h7FFFFFFFFFFF;
                    end else if (sum_lo) begin
                        if (ax_reg) sy_reg <= 48'h800000000000;
                        else sx_reg <= 48'h800000000000;
                    end else if (ax_reg) sy_reg <= tsum[47:0];
                    else sx_reg <= tsum[47:0];
                    if (!ax_reg) begin
                        ax_reg <= 1'b1;
                        st_reg <= S_SD;
                    end else st_reg <= j_reg.last ? S_M0 : S_IDLE;
                end
                S_M0: st_reg <= S_MA;
                S_MA: begin
                    mx_reg <= sx_reg[47] ? -sx_reg : sx_reg;
                    my_reg <= sy_reg[47] ? -sy_reg : sy_reg;
                    sq_reg <= '0;
                    pp_reg <= 3'd0;
                    st_reg <= S_MB;
                end
                S_MB: begin
                    sq_reg <= sq_reg + pterm;
                    if (pp_reg == 3'd5) st_reg <= S_MS;
                    else pp_reg <= pp_reg + 3'd1;
                end
                S_MS: st_reg <= S_MW;
                S_MW: if (!busy) begin
                    mag_reg <= (quo[63:47] != '0) ? MAX47 : quo[46:0];
                    if (quo[63:47] != '0) clip_reg <= 1'b1;
                    st_reg <= S_OUT;
                end
                S_OUT: if (!m_valid) begin
                    m_valid <= 1'b1;
                    m_out_query_x <= j_reg.qx;
                    m_out_query_y <= j_reg.qy;
                    m_force_x <= sx_reg;
                    m_force_y <= sy_reg;
                    m_force_magnitude <= mag_reg;
                    m_saturated <= clip_reg;
                    sx_reg <= '0;
                    sy_reg <= '0;
                    clip_reg <= 1'b0;
                    st_reg <= S_IDLE;
                end
                default: st_reg <= S_IDLE;
            endcase
            if (m_valid && m_ready) m_valid <= 1'b0;
        end
    end
endmodule
`default_nettype wire

// ----- design/obstacle_repulsive_field_sum.sv -----
// Top level of the obstacle repulsive force summer.
// Depends on orfs_pkg, orfs_front, orfs_back.
//
// Input channel s_*: one item per handshake, query point plus optional obstacle.
// Items marked s_last_in_batch close the batch and give one result on m_*.
// Configuration: cfg_we writes cfg_index (0 gain, 1 range) with cfg_data.
// Each in-range obstacle uses one 64-step square root and five 128-step
// divisions on the single shared bit-serial unit, plus control steps.
// Out-of-range or empty items skip that arithmetic; a close adds the
// magnitude square root. A two-entry queue parts front from back.
// The result register holds until m_ready; the back end stalls only
// when it has a new result to write; the front keeps accepting until its queue fills.
// Reset clears sums, flag, queue and restores gain 10.0 and range 30.0.
`timescale 1ns / 1ps
`default_nettype none
module obstacle_repulsive_field_sum import orfs_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [31:0] s_query_x,
    input  wire logic [31:0] s_query_y,
    input  wire logic [31:0] s_obstacle_x,
    input  wire logic [31:0] s_obstacle_y,
    input  wire logic        s_has_obstacle,
    input  wire logic        s_last_in_batch,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_out_query_x,
    output logic [31:0]      m_out_query_y,
    output logic [47:0]      m_force_x,
    output logic [47:0]      m_force_y,
    output logic [46:0]      m_force_magnitude,
    output logic             m_saturated
);
    logic [31:0] gain_reg, range_reg;
    orfs_job_t job;
    logic job_valid, job_take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg <= GAIN_RESET;
            range_reg <= RANGE_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_GAIN: gain_reg <= cfg_data;
                CFG_RANGE: range_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    orfs_front u_front (.aclk(aclk), .aresetn(aresetn), .s_valid(s_valid),
        .s_ready(s_ready), .s_query_x(s_query_x), .s_query_y(s_query_y),
        .s_obstacle_x(s_obstacle_x), .s_obstacle_y(s_obstacle_y),
        .s_has_obstacle(s_has_obstacle), .s_last_in_batch(s_last_in_batch),
        .job(job), .job_valid(job_valid), .job_take(job_take));

    orfs_back u_back (.aclk(aclk), .aresetn(aresetn), .gain(gain_reg),
        .range_r(range_reg), .job(job), .job_valid(job_valid), .job_take(job_take),
        .m_valid(m_valid), .m_ready(m_ready), .m_out_query_x(m_out_query_x),
        .m_out_query_y(m_out_query_y), .m_force_x(m_force_x), .m_force_y(m_force_y),
        .m_force_magnitude(m_force_magnitude), .m_saturated(m_saturated));
endmodule
`default_nettype wire

// ----- tb/orfs_checker.sv -----
// Watches both channels of the obstacle repulsive force summer, predicts each result
// and compares it field by field. Depends on orfs_pkg for widths and register indexes.
`timescale 1ns / 1ps
module orfs_checker import orfs_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        s_valid,
    input  wire logic        s_ready,
    input  wire logic [31:0] s_query_x,
    input  wire logic [31:0] s_query_y,
    input  wire logic [31:0] s_obstacle_x,
    input  wire logic [31:0] s_obstacle_y,
    input  wire logic        s_has_obstacle,
    input  wire logic        s_last_in_batch,
    input  wire logic        m_valid,
    input  wire logic        m_ready,
    input  wire logic [31:0] m_out_query_x,
    input  wire logic [31:0] m_out_query_y,
    input  wire logic [47:0] m_force_x,
    input  wire logic [47:0] m_force_y,
    input  wire logic [46:0] m_force_magnitude,
    input  wire logic        m_saturated,
    output int               fail_count,
    output int               pending_forces
);
    typedef struct {
        logic [31:0] qx;
        logic [31:0] qy;
        logic [47:0] fx;
        logic [47:0] fy;
        logic [46:0] mag;
        logic        sat;
    } force_result_t;

    force_result_t expected_forces[$];
    logic [63:0] gain_k, range_r;
    longint sum_x, sum_y;
    logic clipped;

    assign pending_forces = expected_forces.size();

    function automatic logic [63:0] root_floor(logic [127:0] v);
        logic [127:0] res, bitv;
        res = '0;
        bitv = 128'h1 << 126;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res[63:0];
    endfunction

    function automatic longint axis_force(longint delta, logic [63:0] d, logic [63:0] d2,
                                          logic [63:0] g);
        logic [63:0] mag, s, p;
        logic [127:0] q;
        longint m;
        mag = (delta < 0) ? -delta : delta;
        s = (mag << DIR_BITS) / d;
        p = g * s;
        q = ({64'b0, p} << (2 * FRACTION_BITS)) / {64'b0, d2};
        q = q >> DIR_BITS;
        if (q > {81'b0, MAX47}) begin
            q = {81'b0, MAX47};
            clipped = 1'b1;
        end
        m = longint'(q[63:0]);
        return (delta < 0) ? -m : m;
    endfunction

    function automatic longint clamp_sum(longint a, longint b);
        longint s;
        s = a + b;
        if (s > longint'(MAX47)) begin
            clipped = 1'b1;
            return longint'(MAX47);
        end
        if (s < -longint'(MAX47) - 1) begin
            clipped = 1'b1;
            return -longint'(MAX47) - 1;
        end
        return s;
    endfunction

    function automatic void accumulate_obstacle(longint qx, longint qy, longint ox,
                                                longint oy);
        longint dx, dy;
        logic [63:0] adx, ady, d, g, d2;
        logic [65:0] d2w;
        dx = qx - ox;
        dy = qy - oy;
        adx = (dx < 0) ? -dx : dx;
        ady = (dy < 0) ? -dy : dy;
        if (ox == 0 && oy == 0) return;
        if (adx == 0 && ady == 0) begin
            clipped = 1'b1;
            return;
        end
        if (adx > range_r || ady > range_r) return;
        d2w = 66'(adx) * 66'(adx) + 66'(ady) * 66'(ady);
        if (d2w[65:64] != 2'b0) return;
        d2 = d2w[63:0];
        if (d2 > range_r * range_r) return;
        d = root_floor({64'b0, d2});
        g = (gain_k * (range_r - d)) / range_r;
        sum_x = clamp_sum(sum_x, axis_force(dx, d, d2, g));
        sum_y = clamp_sum(sum_y, axis_force(dy, d, d2, g));
    endfunction

    always @(posedge aclk) begin
        longint ax, ay;
        logic [63:0] root;
        force_result_t r, e;
        if (!aresetn) begin
            gain_k <= 64'(GAIN_RESET);
            range_r <= 64'(RANGE_RESET);
            sum_x = 0;
            sum_y = 0;
            clipped = 1'b0;
            fail_count <= 0;
            expected_forces.delete();
        end else begin
            if (cfg_we) begin
                if (cfg_index == CFG_GAIN) gain_k <= 64'(cfg_data);
                else range_r <= 64'(cfg_data);
            end
            if (s_valid && s_ready) begin
                if (s_has_obstacle)
                    accumulate_obstacle(longint'(signed'(s_query_x)),
                                        longint'(signed'(s_query_y)),
                                        longint'(signed'(s_obstacle_x)),
                                        longint'(signed'(s_obstacle_y)));
                if (s_last_in_batch) begin
                    ax = (sum_x < 0) ? -sum_x : sum_x;
                    ay = (sum_y < 0) ? -sum_y : sum_y;
                    root = root_floor(128'(ax) * 128'(ax) + 128'(ay) * 128'(ay));
                    if (root > 64'(MAX47)) begin
                        root = 64'(MAX47);
                        clipped = 1'b1;
                    end
                    r.qx = s_query_x;
                    r.qy = s_query_y;
                    r.fx = sum_x[47:0];
                    r.fy = sum_y[47:0];
                    r.mag = root[46:0];
                    r.sat = clipped;
                    expected_forces = {expected_forces, r};
                    sum_x = 0;
                    sum_y = 0;
                    clipped = 1'b0;
                end
            end
            if (m_valid && m_ready) begin
                if (expected_forces.size() == 0) begin
                    $error("result with no expectation pending");
                    fail_count <= fail_count + 1;
                end else begin
                    e = expected_forces.pop_front();
                    if (m_out_query_x !== e.qx || m_out_query_y !== e.qy ||
                        m_force_x !== e.fx || m_force_y !== e.fy ||
                        m_force_magnitude !== e.mag || m_saturated !== e.sat)
                        fail_count <= fail_count + 1;
                    if (m_out_query_x !== e.qx)
                        $error("out_query_x expected %h got %h", e.qx, m_out_query_x);
                    if (m_out_query_y !== e.qy)
                        $error("out_query_y expected %h got %h", e.qy, m_out_query_y);
                    if (m_force_x !== e.fx)
                        $error("force_x expected %h got %h", e.fx, m_force_x);
                    if (m_force_y !== e.fy)
                        $error("force_y expected %h got %h", e.fy, m_force_y);
                    if (m_force_magnitude !== e.mag)
                        $error("force_magnitude expected %h got %h", e.mag,
                               m_force_magnitude);
                    if (m_saturated !== e.sat)
                        $error("saturated expected %b got %b", e.sat, m_saturated);
                end
            end
        end
    end
endmodule

// ----- tb/tb.sv -----
// Stimulus and verdict for the obstacle repulsive force summer: directed and random
// obstacle batches over several gain and range settings. Depends on orfs_pkg, orfs_checker.
`timescale 1ns / 1ps
module tb;
    import orfs_pkg::*;

    localparam int WATCHDOG_LIMIT = 40000;

    logic aclk, aresetn;
    logic cfg_we, cfg_index;
    logic [31:0] cfg_data;
    logic s_valid, s_ready, s_has_obstacle, s_last_in_batch;
    logic [31:0] s_query_x, s_query_y, s_obstacle_x, s_obstacle_y;
    logic m_valid, m_ready, m_saturated;
    logic [31:0] m_out_query_x, m_out_query_y;
    logic [47:0] m_force_x, m_force_y;
    logic [46:0] m_force_magnitude;
    int fail_count, pending_forces;
    int send_idle_pct, recv_stall_pct, hold_cycles, idle_cycles;
    logic [31:0] range_now;

    obstacle_repulsive_field_sum dut (.*);
    orfs_checker checker_i (.*);

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_cycles > 0) begin
                hold_cycles = hold_cycles - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    task automatic offer(logic [31:0] qx, logic [31:0] qy, logic [31:0] ox,
                         logic [31:0] oy, logic has, logic last);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge aclk);
        end
        s_query_x <= qx;
        s_query_y <= qy;
        s_obstacle_x <= ox;
        s_obstacle_y <= oy;
        s_has_obstacle <= has;
        s_last_in_batch <= last;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic write_reg(logic idx, logic [31:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge aclk);
        cfg_we <= 1'b0;
        if (idx == CFG_RANGE) range_now = value;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_forces != 0);
        repeat (800) @(negedge aclk);
    endtask

    function automatic logic [31:0] near_coord(logic [31:0] base);
        longint span, off;
        span = (range_now > 32'h3fff_ffff) ? 64'h3fff_ffff : longint'(range_now) + 2;
        off = longint'($urandom_range(32'(2 * span))) - span;
        return base + 32'(off);
    endfunction

    // returns number of items offered
    task automatic random_batch(output int sent);
        logic [31:0] qx, qy, ox, oy;
        int n, kind;
        logic wide, close_empty;
        wide = ($urandom_range(9) < 2);
        qx = wide ? $urandom : 32'($urandom_range(0, 131072000)) - 32'd65536000;
        qy = wide ? $urandom : 32'($urandom_range(0, 131072000)) - 32'd65536000;
        n = $urandom_range(0, 4);
        close_empty = (n == 0) || ($urandom_range(3) == 0);
        sent = 0;
        for (int i = 0; i < n; i++) begin
            kind = $urandom_range(99);
            if (kind < 50) begin
                ox = near_coord(qx);
                oy = near_coord(qy);
            end else if (kind < 58) begin
                ox = 32'h0;
                oy = 32'h0;
            end else if (kind < 64) begin
                ox = qx;
                oy = qy;
            end else begin
                ox = $urandom;
                oy = $urandom;
            end
            if ($urandom_range(9) == 0) begin
                offer(qx, qy, $urandom, $urandom, 1'b0, 1'b0);
                sent++;
            end
            offer(qx, qy, ox, oy, 1'b1, !close_empty && i == n - 1);
            sent++;
        end
        if (close_empty) begin
            offer(qx, qy, $urandom, $urandom, 1'b0, 1'b1);
            sent++;
        end
    endtask

    task automatic directed_default();
        offer(32'h0001_0000, 32'h0002_0000, 32'h0, 32'h0, 1'b1, 1'b1);
        offer(32'h0005_0000, 32'h0005_0000, 32'h0005_0000, 32'h0005_0000, 1'b1, 1'b1);
        offer(32'h0005_0000, 32'h0, 32'h0, 32'h0001_0000, 1'b1, 1'b0);
        offer(32'h0005_0000, 32'h0, 32'h0003_0000, 32'hffff_0000, 1'b1, 1'b0);
        offer(32'h0005_0000, 32'h0, 32'h0050_0000, 32'h0, 1'b1, 1'b0);
        offer(32'h0005_0000, 32'h0, 32'h0023_0000, 32'h0, 1'b1, 1'b0);
        offer(32'h0005_0000, 32'h0, 32'hffe7_0000, 32'h0, 1'b1, 1'b1);
        offer(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 1'b1, 1'b1);
        offer(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_fff0, 32'h7fff_fff0, 1'b1, 1'b1);
        offer(32'h8000_0000, 32'h8000_0000, 32'h8000_0001, 32'h8000_0000, 1'b1, 1'b1);
        offer(32'hffff_ffff, 32'h0, 32'h1234_5678, 32'h0, 1'b0, 1'b0);
        offer(32'hffff_ffff, 32'h0, 32'h0, 32'h0, 1'b0, 1'b1);
        offer(32'h0001_0000, 32'h0001_0000, 32'h001f_0000, 32'h0001_0000, 1'b1, 1'b1);
    endtask

    task automatic directed_clip();
        offer(32'h0000_0010, 32'h0000_0010, 32'h0000_000f, 32'h0000_000f, 1'b1, 1'b0);
        offer(32'h0000_0010, 32'h0000_0010, 32'h0000_000f, 32'h0000_000f, 1'b1, 1'b1);
        offer(32'h0000_0010, 32'h0000_0010, 32'h0000_0011, 32'h0000_0010, 1'b1, 1'b1);
    endtask

    initial begin
        int sent, total;
        logic [31:0] gains[6];
        logic [31:0] ranges[6];
        gains = '{GAIN_RESET, 32'hffff_ffff, 32'h0, 32'h0001_0000, 32'h0, GAIN_RESET};
        ranges = '{RANGE_RESET, RANGE_RESET, 32'hffff_ffff, 32'h0064_0000, 32'h1,
                   RANGE_RESET};
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_GAIN;
        cfg_data = '0;
        s_valid = 1'b0;
        s_query_x = '0;
        s_query_y = '0;
        s_obstacle_x = '0;
        s_obstacle_y = '0;
        s_has_obstacle = 1'b0;
        s_last_in_batch = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_cycles = 0;
        range_now = RANGE_RESET;
        repeat (5) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);
        directed_default();
        for (int ph = 0; ph < 6; ph++) begin
            if (ph > 0) begin
                drain();
                write_reg(CFG_GAIN, ph == 3 ? $urandom : gains[ph]);
                write_reg(CFG_RANGE, ranges[ph]);
            end
            if (ph == 1) directed_clip();
            total = 0;
            for (int q = 0; total < 300; q++) begin
                case ((q / 15) % 4)
                    0: begin send_idle_pct = 0; recv_stall_pct = 0; end
                    1: begin send_idle_pct = 59; recv_stall_pct = 0; end
                    2: begin send_idle_pct = 0; recv_stall_pct = 59; end
                    default: begin send_idle_pct = 16; recv_stall_pct = 16; end
                endcase
                if (ph == 0 && q == 20) begin
                    s_valid <= 1'b0;
                    @(posedge aclk);
                    hold_cycles = 4000;
                    @(negedge aclk);
                end
                random_batch(sent);
                total += sent;
            end
        end
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_forces != 0);
        repeat (800) @(posedge aclk);
        if (fail_count == 0) $display("simulation ok");
        else $display("simulation failed");
        $finish;
    end
endmodule

// ----- files.f -----
design/orfs_pkg.sv
design/orfs_front.sv
design/orfs_seq.sv
design/orfs_back.sv
design/obstacle_repulsive_field_sum.sv
tb/orfs_checker.sv
tb/tb.sv
